// ===== src/bmpw_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpw_pkg
// Shared types, codes and constants of the BMP byte stream to pixel write block.
// ----------------------------------------------------------------------------
package bmpw_pkg;

    localparam int MAX_DIM_DEF       = 2048;
    localparam int PIXEL_DATA_OFFSET = 54;
    localparam int ORIGIN_W          = 11;
    localparam int COORD_W           = 12;
    localparam int MAG_W             = 13;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_NOT_BMP,
        ST_BAD_DEPTH,
        ST_TOO_LARGE
    } status_t;

    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Y = 1'b1;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    localparam logic [5:0] OFF_SIG0        = 6'h00;
    localparam logic [5:0] OFF_SIG1        = 6'h01;
    localparam logic [5:0] OFF_WIDTH       = 6'h12;
    localparam logic [5:0] OFF_HEIGHT      = 6'h16;
    localparam logic [5:0] OFF_HEIGHT_END  = 6'h1A;
    localparam logic [5:0] OFF_DEPTH       = 6'h1C;
    localparam logic [5:0] OFF_DEPTH_HI    = 6'h1D;
    localparam logic [5:0] OFF_DEPTH_END   = 6'h1E;
    localparam logic [5:0] OFF_HEADER_LAST = 6'(PIXEL_DATA_OFFSET - 1);

    localparam logic [15:0] BPP_24 = 16'd24;
    localparam logic [15:0] BPP_32 = 16'd32;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [31:0]        argb_color;
        status_t            status;
        logic               last_pixel;
    } result_t;

    typedef struct packed {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
    } origin_t;

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        magnitude = v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

// ===== src/bmp_stream_to_pixel_writes.sv =====
// ----------------------------------------------------------------------------
// bmp_stream_to_pixel_writes
// BMP file byte stream to screen pixel writes, 24 and 32 bits per pixel.
// ----------------------------------------------------------------------------
// Each accepted request carries one file byte; a new request is taken every
// cycle while the result side keeps up. A byte passes an input register and
// the parser logic into a result register, from which a pixel write or error
// report is presented for the byte that completes it. Padding bytes, non-final
// pixel bytes and header bytes that raise no error produce no result. Mark a
// file's first byte with first_byte to restart the parser; after an error or
// the final pixel, bytes are dropped until the next marked byte. Write the
// origin registers only while no request is in flight.
module bmp_stream_to_pixel_writes #(
    parameter int MAX_DIM = bmpw_pkg::MAX_DIM_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [bmpw_pkg::ORIGIN_W-1:0]     cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_file_byte,
    input  logic                              s_first_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bmpw_pkg::COORD_W-1:0]      m_pixel_x,
    output logic [bmpw_pkg::COORD_W-1:0]      m_pixel_y,
    output logic [31:0]                       m_argb_color,
    output logic [1:0]                        m_status,
    output logic                              m_last_pixel
);
    import bmpw_pkg::*;

    origin_t  origin;
    in_item_t s_item;
    in_item_t item;
    logic     advance;
    logic     consume;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_item.file_byte  = s_file_byte;
    assign s_item.first_byte = s_first_byte;

    bmpw_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .origin    (origin)
    );

    bmpw_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .advance (advance),
        .consume (consume),
        .item    (item)
    );

    bmpw_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .consume   (consume),
        .item      (item),
        .origin    (origin),
        .res_valid (res_valid),
        .res       (res)
    );

    bmpw_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .consume   (consume),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_pixel_x    = m_res.pixel_x;
    assign m_pixel_y    = m_res.pixel_y;
    assign m_argb_color = m_res.argb_color;
    assign m_status     = m_res.status;
    assign m_last_pixel = m_res.last_pixel;

endmodule

// ===== src/bmpw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bmpw_cfg_regs
// Origin registers written through the plain configuration write port.
// ----------------------------------------------------------------------------
module bmpw_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [bmpw_pkg::ORIGIN_W-1:0]      cfg_wdata,
    output bmpw_pkg::origin_t                  origin
);
    import bmpw_pkg::*;

    origin_t origin_reg;
    origin_t origin_next;

    always_comb begin
        origin_next = origin_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_next.origin_x = cfg_wdata;
                CFG_ORIGIN_Y: origin_next.origin_y = cfg_wdata;
                default:      origin_next = origin_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg <= '0;
        end else begin
            origin_reg <= origin_next;
        end
    end

    assign origin = origin_reg;

endmodule

// ===== src/bmpw_in_stage.sv =====
// ----------------------------------------------------------------------------
// bmpw_in_stage
// Input register holding one file byte request until the parser takes it.
// ----------------------------------------------------------------------------
module bmpw_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bmpw_pkg::in_item_t  s_item,
    input  logic                advance,
    output logic                consume,
    output bmpw_pkg::in_item_t  item
);
    import bmpw_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign consume = valid_reg && advance;
    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

    assign item = item_reg;

endmodule

// ===== src/bmpw_parser.sv =====
// ----------------------------------------------------------------------------
// bmpw_parser
// Header parse, pixel packing, padding skip and screen coordinate generation.
// ----------------------------------------------------------------------------
module bmpw_parser #(
    parameter int MAX_DIM = bmpw_pkg::MAX_DIM_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                consume,
    input  bmpw_pkg::in_item_t  item,
    input  bmpw_pkg::origin_t   origin,
    output logic                res_valid,
    output bmpw_pkg::result_t   res
);
    import bmpw_pkg::*;

    phase_t             phase_reg, phase_next, phase_c;
    logic [5:0]         off_reg, off_next, off_c;
    logic [31:0]        width_reg, width_next, width_c;
    logic [31:0]        height_reg, height_next, height_c;
    logic [15:0]        bpp_reg, bpp_next, bpp_c;
    logic [COORD_W-1:0] col_reg, col_next, col_c;
    logic [COORD_W-1:0] row_reg, row_next, row_c;
    logic [1:0]         bip_reg, bip_next, bip_c;
    logic [1:0]         pad_reg, pad_next, pad_c;
    logic [23:0]        partial_reg, partial_next, partial_c;
    logic [MAG_W-1:0]   wmag_reg, wmag_next;
    logic [MAG_W-1:0]   hmag_reg, hmag_next;

    logic               clear;
    logic [7:0]         b;
    logic [1:0]         lane_w;
    logic [1:0]         lane_h;
    logic               lane_d;
    logic [15:0]        bpp_new;
    logic [31:0]        wmag_full;
    logic [31:0]        hmag_full;
    logic               hdr_err;
    logic               need32;
    logic               px_done;
    logic [23:0]        color_lo;
    logic [7:0]         alpha;
    logic               col_end;
    logic               row_end;
    logic [1:0]         pad_load;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] wmag12;
    logic [COORD_W-1:0] hmag12;

    assign clear     = item.first_byte;
    assign b         = item.file_byte;
    assign phase_c   = clear ? PH_HEADER : phase_reg;
    assign off_c     = clear ? 6'd0 : off_reg;
    assign width_c   = clear ? 32'd0 : width_reg;
    assign height_c  = clear ? 32'd0 : height_reg;
    assign bpp_c     = clear ? 16'd0 : bpp_reg;
    assign col_c     = clear ? '0 : col_reg;
    assign row_c     = clear ? '0 : row_reg;
    assign bip_c     = clear ? 2'd0 : bip_reg;
    assign pad_c     = clear ? 2'd0 : pad_reg;
    assign partial_c = clear ? 24'd0 : partial_reg;

    assign lane_w    = 2'(off_c - OFF_WIDTH);
    assign lane_h    = 2'(off_c - OFF_HEIGHT);
    assign lane_d    = 1'(off_c - OFF_DEPTH);
    assign bpp_new   = bpp_c | ({8'd0, b} << {lane_d, 3'b000});
    assign wmag_full = magnitude(width_c);
    assign hmag_full = magnitude(height_c);

    assign need32    = (bpp_c == BPP_32);
    assign px_done   = need32 ? (bip_c == 2'd3) : (bip_c >= 2'd2);
    assign color_lo  = (bip_c != 2'd3) ? (partial_c | (24'(b) << {bip_c, 3'b000})) : partial_c;
    assign alpha     = (bip_c == 2'd3) ? b : 8'd0;
    assign col_end   = ({1'b0, col_c} + 13'd1) >= 13'(wmag_reg);
    assign row_end   = ({1'b0, row_c} + 13'd1) >= 13'(hmag_reg);
    assign pad_load  = need32 ? 2'd0 : wmag_reg[1:0];
    assign ox        = COORD_W'(origin.origin_x);
    assign oy        = COORD_W'(origin.origin_y);
    assign wmag12    = COORD_W'(wmag_reg);
    assign hmag12    = COORD_W'(hmag_reg);

    always_comb begin
        phase_next   = phase_c;
        off_next     = off_c;
        width_next   = width_c;
        height_next  = height_c;
        bpp_next     = bpp_c;
        col_next     = col_c;
        row_next     = row_c;
        bip_next     = bip_c;
        pad_next     = pad_c;
        partial_next = partial_c;
        wmag_next    = wmag_reg;
        hmag_next    = hmag_reg;
        hdr_err      = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        res.status   = ST_PIXEL;

        case (phase_c)
            PH_HEADER: begin
                if (off_c == OFF_SIG0) begin
                    partial_next = {16'd0, b};
                end else if (off_c == OFF_SIG1) begin
                    if (partial_c != {16'd0, SIG_B} || b != SIG_M) begin
                        hdr_err    = 1'b1;
                        res.status = ST_NOT_BMP;
                    end else begin
                        partial_next = 24'd0;
                    end
                end else if (off_c >= OFF_WIDTH && off_c < OFF_HEIGHT) begin
                    width_next = width_c | ({24'd0, b} << {lane_w, 3'b000});
                end else if (off_c >= OFF_HEIGHT && off_c < OFF_HEIGHT_END) begin
                    height_next = height_c | ({24'd0, b} << {lane_h, 3'b000});
                end else if (off_c >= OFF_DEPTH && off_c < OFF_DEPTH_END) begin
                    bpp_next = bpp_new;
                    if (off_c == OFF_DEPTH_HI) begin
                        wmag_next = MAG_W'(wmag_full);
                        hmag_next = MAG_W'(hmag_full);
                        if (bpp_new != BPP_24 && bpp_new != BPP_32) begin
                            hdr_err    = 1'b1;
                            res.status = ST_BAD_DEPTH;
                        end else if (wmag_full > 32'(MAX_DIM) ||
                                     hmag_full > 32'(MAX_DIM)) begin
                            hdr_err    = 1'b1;
                            res.status = ST_TOO_LARGE;
                        end
                    end
                end

                if (hdr_err) begin
                    res_valid  = 1'b1;
                    phase_next = PH_IDLE;
                end else if (off_c >= OFF_HEADER_LAST) begin
                    phase_next = (width_c == 32'd0 || height_c == 32'd0) ? PH_IDLE : PH_PIXEL;
                end else begin
                    off_next = off_c + 6'd1;
                end
            end

            PH_PIXEL: begin
                if (!px_done) begin
                    partial_next = color_lo;
                    bip_next     = bip_c + 2'd1;
                end else begin
                    bip_next       = 2'd0;
                    partial_next   = 24'd0;
                    res_valid      = 1'b1;
                    res.argb_color = {alpha, color_lo};
                    res.pixel_x    = width_c[31] ? (ox + wmag12 - col_c - 12'd1) : (ox + col_c);
                    res.pixel_y    = height_c[31] ? (oy + row_c) : (oy + hmag12 - row_c - 12'd1);
                    if (col_end) begin
                        col_next = '0;
                        if (row_end) begin
                            res.last_pixel = 1'b1;
                            phase_next     = PH_IDLE;
                        end else begin
                            row_next = row_c + 12'd1;
                            pad_next = pad_load;
                            if (pad_load != 2'd0) begin
                                phase_next = PH_PAD;
                            end
                        end
                    end else begin
                        col_next = col_c + 12'd1;
                    end
                end
            end

            PH_PAD: begin
                pad_next = pad_c - 2'd1;
                if (pad_c == 2'd1) begin
                    phase_next = PH_PIXEL;
                end
            end

            default: begin
                phase_next = phase_c;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            off_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            bpp_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            bip_reg     <= '0;
            pad_reg     <= '0;
            partial_reg <= '0;
        end else if (consume) begin
            phase_reg   <= phase_next;
            off_reg     <= off_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            bpp_reg     <= bpp_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            bip_reg     <= bip_next;
            pad_reg     <= pad_next;
            partial_reg <= partial_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            wmag_reg <= wmag_next;
            hmag_reg <= hmag_next;
        end
    end

endmodule

// ===== src/bmpw_out_stage.sv =====
// ----------------------------------------------------------------------------
// bmpw_out_stage
// Result register presenting pixel writes and error reports downstream.
// ----------------------------------------------------------------------------
module bmpw_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               consume,
    input  logic               res_valid,
    input  bmpw_pkg::result_t  res,
    output logic               advance,
    output logic               m_valid,
    input  logic               m_ready,
    output bmpw_pkg::result_t  m_res
);
    import bmpw_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    load;

    assign advance = !valid_reg || m_ready;
    assign load    = consume && res_valid;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== tb/tb_bmp_stream_to_pixel_writes.sv =====
// ----------------------------------------------------------------------------
// tb_bmp_stream_to_pixel_writes
// Streams BMP files byte by byte into the decoder and checks every pixel write
// and error report against a cycle-free model of the parser. Covers 24 and
// 32 bit images in all four orientations, row padding, header errors, empty
// images, restarts mid-file and trailing bytes, under several origin settings
// and with random idling on both channels plus a long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_bmp_stream_to_pixel_writes;
    import bmpw_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;

    class pixel_write_tracker;
        logic [ORIGIN_W-1:0] org_x;
        logic [ORIGIN_W-1:0] org_y;
        logic [5:0]          hdr_offset;
        logic [31:0]         img_w;
        logic [31:0]         img_h;
        logic [15:0]         depth;
        logic [11:0]         col;
        logic [11:0]         row;
        logic [1:0]          byte_idx;
        logic [1:0]          pad_left;
        logic [23:0]         color_acc;
        phase_t              phase;
        result_t             pending_writes[$];
        int                  mismatches;
        int                  pixels_checked;
        int                  reports_checked;

        function new();
            org_x = '0;
            org_y = '0;
            mismatches = 0;
            pixels_checked = 0;
            reports_checked = 0;
            restart();
        endfunction

        function void restart();
            hdr_offset = '0;
            img_w = '0;
            img_h = '0;
            depth = '0;
            col = '0;
            row = '0;
            byte_idx = '0;
            pad_left = '0;
            color_acc = '0;
            phase = PH_HEADER;
        endfunction

        function void set_origin(logic idx, logic [ORIGIN_W-1:0] val);
            if (idx == CFG_ORIGIN_X) begin
                org_x = val;
            end else begin
                org_y = val;
            end
        endfunction

        function logic [31:0] mag(logic [31:0] v);
            return v[31] ? -v : v;
        endfunction

        function void push_report(status_t code);
            result_t r;
            r = '0;
            r.status = code;
            pending_writes.push_back(r);
            phase = PH_IDLE;
        endfunction

        function void take_header(logic [7:0] b);
            logic [5:0] off;
            off = hdr_offset;
            if (off == OFF_SIG0) begin
                color_acc = {16'd0, b};
            end else if (off == OFF_SIG1) begin
                if (color_acc != {16'd0, SIG_B} || b != SIG_M) begin
                    push_report(ST_NOT_BMP);
                    return;
                end
                color_acc = '0;
            end else if (off >= OFF_WIDTH && off < OFF_HEIGHT) begin
                img_w |= 32'(b) << (8 * (off - OFF_WIDTH));
            end else if (off >= OFF_HEIGHT && off < OFF_HEIGHT_END) begin
                img_h |= 32'(b) << (8 * (off - OFF_HEIGHT));
            end else if (off >= OFF_DEPTH && off < OFF_DEPTH_END) begin
                depth |= 16'(b) << (8 * (off - OFF_DEPTH));
                if (off == OFF_DEPTH_HI) begin
                    if (depth != BPP_24 && depth != BPP_32) begin
                        push_report(ST_BAD_DEPTH);
                        return;
                    end
                    if (mag(img_w) > MAX_DIM_DEF || mag(img_h) > MAX_DIM_DEF) begin
                        push_report(ST_TOO_LARGE);
                        return;
                    end
                end
            end
            if (int'(off) + 1 >= PIXEL_DATA_OFFSET) begin
                phase = (img_w == 0 || img_h == 0) ? PH_IDLE : PH_PIXEL;
            end else begin
                hdr_offset = off + 6'd1;
            end
        endfunction

        function void take_pixel(logic [7:0] b);
            logic [31:0] wmag;
            logic [31:0] hmag;
            logic [31:0] x;
            logic [31:0] y;
            logic [7:0]  alpha;
            int          need;
            result_t     r;
            wmag = mag(img_w);
            hmag = mag(img_h);
            need = (depth == BPP_32) ? 4 : 3;
            alpha = '0;
            if (byte_idx < 2'd3) begin
                color_acc = color_acc | (24'(b) << (8 * byte_idx));
            end else begin
                alpha = b;
            end
            if (int'(byte_idx) + 1 < need) begin
                byte_idx = byte_idx + 2'd1;
                return;
            end
            r = '0;
            r.argb_color = {alpha, color_acc};
            byte_idx = '0;
            color_acc = '0;
            x = img_w[31] ? 32'(org_x) + wmag - 32'(col) - 1 : 32'(org_x) + 32'(col);
            y = img_h[31] ? 32'(org_y) + 32'(row) : 32'(org_y) + hmag - 32'(row) - 1;
            if (32'(col) + 1 >= wmag) begin
                col = '0;
                if (32'(row) + 1 >= hmag) begin
                    r.last_pixel = 1'b1;
                    phase = PH_IDLE;
                end else begin
                    row = row + 12'd1;
                    pad_left = (need == 3) ? wmag[1:0] : 2'd0;
                    if (pad_left != 2'd0) begin
                        phase = PH_PAD;
                    end
                end
            end else begin
                col = col + 12'd1;
            end
            r.pixel_x = x[COORD_W-1:0];
            r.pixel_y = y[COORD_W-1:0];
            r.status = ST_PIXEL;
            pending_writes.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b, logic first);
            if (first) begin
                restart();
            end
            case (phase)
                PH_HEADER: take_header(b);
                PH_PIXEL: take_pixel(b);
                PH_PAD: begin
                    pad_left = pad_left - 2'd1;
                    if (pad_left == 2'd0) begin
                        phase = PH_PIXEL;
                    end
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected x=%0d y=%0d argb=%08h status=%0d last=%0b",
                         what, want.pixel_x, want.pixel_y, want.argb_color,
                         want.status, want.last_pixel);
                $display("    got      x=%0d y=%0d argb=%08h status=%0d last=%0b",
                         got.pixel_x, got.pixel_y, got.argb_color,
                         got.status, got.last_pixel);
            end
        endfunction

        function void match_write(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [31:0] argb, logic [1:0] status, logic last);
            result_t got;
            result_t want;
            got.pixel_x = x;
            got.pixel_y = y;
            got.argb_color = argb;
            got.status = status_t'(status);
            got.last_pixel = last;
            if (pending_writes.size() == 0) begin
                flag("unexpected write", '0, got);
                return;
            end
            want = pending_writes.pop_front();
            if (want.status == ST_PIXEL) begin
                pixels_checked++;
            end else begin
                reports_checked++;
            end
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                got.argb_color !== want.argb_color || got.status !== want.status ||
                got.last_pixel !== want.last_pixel) begin
                flag("write mismatch", want, got);
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_index = CFG_ORIGIN_X;
    logic [ORIGIN_W-1:0] cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [7:0]          s_file_byte = '0;
    logic                s_first_byte = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [COORD_W-1:0]  m_pixel_x;
    logic [COORD_W-1:0]  m_pixel_y;
    logic [31:0]         m_argb_color;
    logic [1:0]          m_status;
    logic                m_last_pixel;

    logic                hold_off = 1'b0;
    int                  idle_pct = 0;
    int                  stall_pct = 0;
    int                  quiet_cycles = 0;
    int                  bytes_sent = 0;
    int                  files_built = 0;
    logic [8:0]          byte_q[$];
    pixel_write_tracker  tracker = new();

    bmp_stream_to_pixel_writes dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_file_byte (s_file_byte),
        .s_first_byte(s_first_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_x   (m_pixel_x),
        .m_pixel_y   (m_pixel_y),
        .m_argb_color(m_argb_color),
        .m_status    (m_status),
        .m_last_pixel(m_last_pixel)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            tracker.take_byte(s_file_byte, s_first_byte);
        end
        if (aresetn && m_valid && m_ready) begin
            tracker.match_write(m_pixel_x, m_pixel_y, m_argb_color, m_status, m_last_pixel);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_bmp_stream_to_pixel_writes: errors");
            $finish;
        end
    end

    task automatic write_origin(logic idx, logic [ORIGIN_W-1:0] val);
        while (tracker.pending_writes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_origin(idx, val);
    endtask

    task automatic send_byte(logic [7:0] b, logic first);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_file_byte <= b;
        s_first_byte <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_queued();
        logic [8:0] item;
        while (byte_q.size() != 0) begin
            item = byte_q.pop_front();
            send_byte(item[7:0], item[8]);
        end
        s_valid <= 1'b0;
    endtask

    // queue one file: header, pixel rows with padding, trailing bytes; cut > 0 truncates
    task automatic add_file(logic [31:0] wid, logic [31:0] hgt, logic [15:0] bpp,
                            bit bad_sig, int cut, int trailing, bit mark);
        logic [7:0] hdr[PIXEL_DATA_OFFSET];
        logic [8:0] file_q[$];
        int         wmag;
        int         hmag;
        int         row_bytes;
        int         pad;
        int         keep;
        for (int i = 0; i < PIXEL_DATA_OFFSET; i++) begin
            hdr[i] = 8'($urandom);
        end
        hdr[OFF_SIG0] = SIG_B;
        hdr[OFF_SIG1] = SIG_M;
        if (bad_sig) begin
            hdr[OFF_SIG0] = 8'($urandom);
            hdr[OFF_SIG1] = 8'($urandom);
            if (hdr[OFF_SIG0] == SIG_B && hdr[OFF_SIG1] == SIG_M) begin
                hdr[OFF_SIG1][0] = ~hdr[OFF_SIG1][0];
            end
        end
        for (int k = 0; k < 4; k++) begin
            hdr[int'(OFF_WIDTH) + k] = wid[8*k +: 8];
            hdr[int'(OFF_HEIGHT) + k] = hgt[8*k +: 8];
        end
        hdr[OFF_DEPTH] = bpp[7:0];
        hdr[OFF_DEPTH_HI] = bpp[15:8];
        for (int i = 0; i < PIXEL_DATA_OFFSET; i++) begin
            file_q.push_back({1'b0, hdr[i]});
        end
        wmag = wid[31] ? int'(-wid) : int'(wid);
        hmag = hgt[31] ? int'(-hgt) : int'(hgt);
        if (!bad_sig && (bpp == BPP_24 || bpp == BPP_32) && wmag > 0 && hmag > 0 &&
            wmag <= MAX_DIM_DEF && hmag <= MAX_DIM_DEF) begin
            row_bytes = wmag * ((bpp == BPP_32) ? 4 : 3);
            pad = (bpp == BPP_24) ? wmag % 4 : 0;
            for (int r = 0; r < hmag; r++) begin
                for (int j = 0; j < row_bytes + pad; j++) begin
                    file_q.push_back({1'b0, 8'($urandom)});
                end
            end
        end
        for (int t = 0; t < trailing; t++) begin
            file_q.push_back({1'b0, 8'($urandom)});
        end
        file_q[0][8] = mark;
        keep = (cut > 0 && cut < file_q.size()) ? cut : file_q.size();
        for (int i = 0; i < keep; i++) begin
            byte_q.push_back(file_q[i]);
        end
        files_built++;
    endtask

    task automatic add_random_file();
        int          pick;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] bpp;
        pick = $urandom_range(0, 99);
        w = 32'($urandom_range(1, 7));
        h = 32'($urandom_range(1, 5));
        if ($urandom_range(0, 1)) w = -w;
        if ($urandom_range(0, 1)) h = -h;
        bpp = $urandom_range(0, 1) ? BPP_32 : BPP_24;
        if (pick < 70) begin
            add_file(w, h, bpp, 0,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : 0,
                     $urandom_range(0, 3), 1);
        end else if (pick < 76) begin
            bpp = 16'($urandom);
            if (bpp == BPP_24 || bpp == BPP_32) bpp[0] = 1'b1;
            add_file(w, h, bpp, 0, $urandom_range(30, 40), 0, 1);
        end else if (pick < 82) begin
            if ($urandom_range(0, 1)) begin
                w = ($urandom_range(0, 3) == 0) ? 32'($urandom) | 32'h0010_0000
                                                : 32'($urandom_range(2049, 4096));
                if ($urandom_range(0, 1)) w = -w;
            end else begin
                h = 32'($urandom_range(2049, 4096));
                if ($urandom_range(0, 1)) h = -h;
            end
            add_file(w, h, bpp, 0, $urandom_range(30, 40), 0, 1);
        end else if (pick < 86) begin
            if ($urandom_range(0, 1)) w = '0; else h = '0;
            add_file(w, h, bpp, 0, 0, $urandom_range(0, 4), 1);
        end else if (pick < 90) begin
            add_file(w, h, bpp, 1, $urandom_range(2, 6), 0, 1);
        end else if (pick < 94) begin
            if ($urandom_range(0, 1)) begin
                w = $urandom_range(0, 1) ? 32'd2048 : -32'd2048;
                h = 32'd1;
            end else begin
                w = 32'd1;
                h = $urandom_range(0, 1) ? 32'd2048 : -32'd2048;
            end
            add_file(w, h, bpp, 0, PIXEL_DATA_OFFSET + $urandom_range(8, 40), 0, 1);
        end else begin
            repeat ($urandom_range(1, 4)) byte_q.push_back(9'($urandom));
        end
    endtask

    task automatic run_phase(int send_idle, int recv_stall,
                             logic [ORIGIN_W-1:0] ox, logic [ORIGIN_W-1:0] oy, int budget);
        int start;
        write_origin(CFG_ORIGIN_X, ox);
        write_origin(CFG_ORIGIN_Y, oy);
        idle_pct = send_idle;
        stall_pct <= recv_stall;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            add_random_file();
            send_queued();
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_origin(CFG_ORIGIN_X, '0);
        write_origin(CFG_ORIGIN_Y, '0);
        add_file(32'd3, 32'd2, BPP_24, 0, 0, 0, 0);
        add_file(-32'd2, -32'd2, BPP_32, 0, 0, 0, 1);
        add_file(32'd2, 32'd2, BPP_24, 1, 4, 0, 1);
        add_file(32'd2, 32'd2, 16'd16, 0, 32, 0, 1);
        add_file(32'd2, 32'd2, 16'h0118, 0, 32, 0, 1);
        add_file(32'd2049, 32'd2, BPP_24, 0, 32, 0, 1);
        add_file(32'd2, -32'd2049, BPP_32, 0, 32, 0, 1);
        add_file(32'h8000_0000, 32'd1, BPP_24, 0, 32, 0, 1);
        add_file(32'd0, 32'd3, BPP_24, 0, 0, 2, 1);
        add_file(32'd3, 32'd0, BPP_32, 0, 0, 2, 1);
        add_file(32'd1, 32'd1, BPP_24, 0, 0, 6, 1);
        add_file(32'd5, 32'd2, BPP_24, 0, 0, 0, 1);
        add_file(-32'd6, 32'd1, BPP_24, 0, 0, 0, 1);
        add_file(32'd4, 32'd3, BPP_24, 0, 20, 0, 1);
        add_file(-32'd3, 32'd2, BPP_24, 0, PIXEL_DATA_OFFSET + 10, 0, 1);
        add_file(32'd2048, 32'd1, BPP_24, 0, PIXEL_DATA_OFFSET + 30, 0, 1);
        add_file(32'd1, -32'd2048, BPP_32, 0, PIXEL_DATA_OFFSET + 30, 0, 1);
        send_queued();

        write_origin(CFG_ORIGIN_X, 11'd2047);
        write_origin(CFG_ORIGIN_Y, 11'd2047);
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off <= 1'b0;
            end
        join_none
        add_file(32'd4, -32'd4, BPP_32, 0, 0, 0, 1);
        add_file(-32'd2048, 32'd1, BPP_24, 0, PIXEL_DATA_OFFSET + 30, 0, 1);
        send_queued();

        run_phase(59, 0, '0, 11'd2047, 20);
        run_phase(0, 59, 11'd2047, '0, 20);
        run_phase(11, 11, 11'($urandom), 11'($urandom), 20);

        while (tracker.pending_writes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("%0d file bytes over %0d streamed files under five origin settings",
                 bytes_sent, files_built);
        $display("%0d pixel writes and %0d error reports checked, %0d mismatches",
                 tracker.pixels_checked, tracker.reports_checked, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_writes.size() == 0) begin
            $display("tb_bmp_stream_to_pixel_writes: clean");
        end else begin
            $display("tb_bmp_stream_to_pixel_writes: errors");
        end
        $finish;
    end

endmodule

// ===== bmp_stream_to_pixel_writes.f =====
src/bmpw_pkg.sv
src/bmpw_cfg_regs.sv
src/bmpw_in_stage.sv
src/bmpw_parser.sv
src/bmpw_out_stage.sv
src/bmp_stream_to_pixel_writes.sv
tb/tb_bmp_stream_to_pixel_writes.sv
